// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, disabled while rst_ni is low.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/mdsg_pkg.sv
`default_nettype none

package mdsg_pkg;

  localparam int unsigned MOTORS_DEF  = 6;
  localparam int unsigned MOTOR_IDX_W = 3;
  localparam int unsigned FREQ_W      = 23;
  localparam int unsigned MAX_FREQ_W  = 15;
  localparam int unsigned SCALE_W     = 26;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned LEVELS_W    = 6;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 26;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned INC_SHIFT   = 16;
  localparam int unsigned PROD_W      = FREQ_W + SCALE_W;

  localparam logic [MAX_FREQ_W-1:0] MAX_FREQ_RST = 15'd20000;
  localparam logic [SCALE_W-1:0]    SCALE_RST    = 26'd27487791;
  // 1 Hz in Q.8
  localparam logic [FREQ_W-1:0]     FREQ_ONE_HZ  = 23'd256;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_SET_FREQ = 2'd1,
    OP_SET_DIR  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FREQ    = 1'b0,
    CFG_PHASE_SCALE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [MAX_FREQ_W-1:0] max_frequency;
    logic [SCALE_W-1:0]    phase_scale;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/multi_axis_dds_step_generator.sv
// Multi-axis DDS step-pulse generator.
// Input stream (s_axis): one beat is one command. tuser carries the opcode:
// tick, set frequency or set direction. tdata carries motor index,
// frequency (Q.8 Hz) and the forward flag.
// Output stream (m_axis): exactly one beat per command, holding the step and
// direction pin levels of motors 0..5 after that command.
// Config port: cfg_we_i writes register cfg_addr_i (0 max frequency in Hz,
// 1 phase scale) at the clock edge; write only while the block is idle.
// Per-motor phase accumulators and increments live in two simple dual-port
// synchronous RAMs (one write, one read port). A tick streams the motors
// through a read / add-write pipeline, one motor per cycle. Set frequency runs
// through a three-stage clamp / multiply / saturate unit. Set direction and
// ignored commands go straight to the result stage. One command is in work at
// a time; s_axis_tready returns the cycle after the result is loaded.
// Reset clears all accumulators, increments, pulses and directions at once.
// When m_axis stalls, the result waits in the output register; the next
// command is accepted meanwhile but its result is held, with s_axis_tready
// low, until the slot frees.
`default_nettype none
`include "assert_macros.svh"

module multi_axis_dds_step_generator #(
  parameter int unsigned MOTORS = mdsg_pkg::MOTORS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // stream in
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [2:0] motor_index, [25:3] frequency_q8, [26] forward_flag, rest zero
  input  wire logic [mdsg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] opcode
  input  wire logic [mdsg_pkg::OP_W-1:0]         s_axis_tuser,
  // stream out
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [5:0] step_levels, [11:6] direction_levels, rest zero
  output logic      [mdsg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [mdsg_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  wire logic [mdsg_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  import mdsg_pkg::*;

  localparam int unsigned IdxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MOTORS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_FREQ,
    ST_FINISH
  } state_e;

  state_e                  state_q;
  cfg_t                    cfg_q;
  logic [IdxW-1:0]         rd_idx_q;
  logic                    rd_busy_q;
  logic [IdxW-1:0]         wr_idx_q;
  logic                    wr_vld_q;
  logic [IdxW-1:0]         set_idx_q;
  logic [MOTORS-1:0]       pulse_q;
  logic [MOTORS-1:0]       dir_q;
  logic                    m_valid_q;
  logic [OUT_TDATA_W-1:0]  m_data_q;

  op_e                     in_op;
  logic [MOTOR_IDX_W-1:0]  in_idx;
  logic [FREQ_W-1:0]       in_freq;
  logic                    in_fwd;
  logic                    idx_ok;
  logic                    accept;

  logic [PHASE_W-1:0]      acc_rd;
  logic [PHASE_W-1:0]      inc_rd;
  logic [PHASE_W:0]        sum;
  logic                    inc_nz;
  logic                    acc_we;
  logic                    calc_start;
  logic                    calc_done;
  logic [PHASE_W-1:0]      calc_incr;
  logic [LEVELS_W-1:0]     step_lv;
  logic [LEVELS_W-1:0]     dir_lv;

  assign in_op   = op_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[MOTOR_IDX_W-1:0];
  assign in_freq = s_axis_tdata[MOTOR_IDX_W +: FREQ_W];
  assign in_fwd  = s_axis_tdata[MOTOR_IDX_W + FREQ_W];
  assign idx_ok  = (32'(in_idx) < MOTORS);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign calc_start    = accept && (in_op == OP_SET_FREQ) && idx_ok;

  // tick write stage: data from the reads issued last cycle
  assign sum    = {1'b0, acc_rd} + {1'b0, inc_rd};
  assign inc_nz = |inc_rd;
  assign acc_we = wr_vld_q & inc_nz;

  mdsg_ram #(
    .DEPTH  (MOTORS),
    .WIDTH  (PHASE_W),
    .ADDR_W (IdxW)
  ) u_acc_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (acc_we),
    .wr_addr_i (wr_idx_q),
    .wr_data_i (sum[PHASE_W-1:0]),
    .rd_en_i   (rd_busy_q),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (acc_rd)
  );

  mdsg_ram #(
    .DEPTH  (MOTORS),
    .WIDTH  (PHASE_W),
    .ADDR_W (IdxW)
  ) u_inc_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (calc_done),
    .wr_addr_i (set_idx_q),
    .wr_data_i (calc_incr),
    .rd_en_i   (rd_busy_q),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (inc_rd)
  );

  mdsg_incr_calc u_incr_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (calc_start),
    .freq_i  (in_freq),
    .cfg_i   (cfg_q),
    .done_o  (calc_done),
    .incr_o  (calc_incr)
  );

  // only motors 0..5 are reported
  for (genvar g = 0; g < LEVELS_W; g++) begin : g_levels
    if (g < MOTORS) begin : g_used
      assign step_lv[g] = pulse_q[g];
      assign dir_lv[g]  = dir_q[g];
    end else begin : g_unused
      assign step_lv[g] = 1'b0;
      assign dir_lv[g]  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= '{max_frequency: MAX_FREQ_RST, phase_scale: SCALE_RST};
      rd_idx_q  <= '0;
      rd_busy_q <= 1'b0;
      wr_idx_q  <= '0;
      wr_vld_q  <= 1'b0;
      set_idx_q <= '0;
      pulse_q   <= '0;
      dir_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_MAX_FREQ:    cfg_q.max_frequency <= cfg_wdata_i[MAX_FREQ_W-1:0];
          CFG_PHASE_SCALE: cfg_q.phase_scale   <= cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end

      // read issue stage
      wr_vld_q <= rd_busy_q;
      wr_idx_q <= rd_idx_q;
      if (rd_busy_q) begin
        if (rd_idx_q == LastIdx) begin
          rd_busy_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end

      // pulse lasts one tick: rewritten on every tick for every motor
      if (wr_vld_q) begin
        pulse_q[wr_idx_q] <= inc_nz & sum[PHASE_W];
      end

      // in ST_FINISH the output slot is reloaded below
      if (m_valid_q && m_axis_tready && (state_q != ST_FINISH)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            set_idx_q <= IdxW'(in_idx);
            case (in_op)
              OP_TICK: begin
                rd_idx_q  <= '0;
                rd_busy_q <= 1'b1;
                state_q   <= ST_TICK;
              end
              OP_SET_FREQ: begin
                state_q <= idx_ok ? ST_FREQ : ST_FINISH;
              end
              OP_SET_DIR: begin
                if (idx_ok) begin
                  dir_q[IdxW'(in_idx)] <= in_fwd;
                end
                state_q <= ST_FINISH;
              end
              default: begin
                state_q <= ST_FINISH;
              end
            endcase
          end
        end
        ST_TICK: begin
          if (wr_vld_q && (wr_idx_q == LastIdx)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FREQ: begin
          if (calc_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= OUT_TDATA_W'({dir_lv, step_lv});
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `ASSERT_IMPL(a_acc_no_overlap, acc_we && rd_busy_q, wr_idx_q != rd_idx_q)
  `ASSERT_IMPL(a_calc_in_freq, calc_done, state_q == ST_FREQ)
  `ASSERT_IMPL(a_tick_pipe_in_tick, rd_busy_q || wr_vld_q, state_q == ST_TICK)
  `ASSERT_NEXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, state_q != ST_IDLE)

endmodule

`default_nettype wire

// File: src/mdsg_ram.sv
`default_nettype none

module mdsg_ram #(
  parameter int unsigned DEPTH  = 6,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// File: src/mdsg_incr_calc.sv
`default_nettype none

module mdsg_incr_calc (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mdsg_pkg::FREQ_W-1:0]   freq_i,
  input  wire mdsg_pkg::cfg_t                cfg_i,
  output logic                               done_o,
  output logic      [mdsg_pkg::PHASE_W-1:0]  incr_o
);

  import mdsg_pkg::*;

  logic [FREQ_W-1:0]  limit;
  logic [FREQ_W-1:0]  f_clamp;
  logic [FREQ_W-1:0]  f_q;
  logic [PROD_W-1:0]  prod_q;
  logic [PHASE_W-1:0] incr_q;
  logic [2:0]         vld_q;
  logic               sat;

  assign limit = {cfg_i.max_frequency, FRAC_BITS'(0)};

  always_comb begin
    if (freq_i < FREQ_ONE_HZ) begin
      f_clamp = '0;
    end else if (freq_i > limit) begin
      f_clamp = limit;
    end else begin
      f_clamp = freq_i;
    end
  end

  assign sat = |prod_q[PROD_W-1:INC_SHIFT+PHASE_W];

  always_ff @(posedge clk_i) begin
    f_q    <= f_clamp;
    prod_q <= PROD_W'(f_q) * PROD_W'(cfg_i.phase_scale);
    incr_q <= sat ? '1 : prod_q[INC_SHIFT +: PHASE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  assign done_o = vld_q[2];
  assign incr_o = incr_q;

endmodule

`default_nettype wire

// File: sim/mdsg_checker.sv
module mdsg_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // [2:0] motor_index, [25:3] frequency_q8, [26] forward_flag, rest zero
  input  logic [mdsg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [mdsg_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [5:0] step_levels, [11:6] direction_levels, rest zero
  input  logic [mdsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [mdsg_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [mdsg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output int                               errors_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mdsg_pkg::*;

  typedef struct packed {
    logic [LEVELS_W-1:0] dirs;
    logic [LEVELS_W-1:0] steps;
  } pin_levels_t;

  logic [PHASE_W-1:0]    accum [MOTORS_DEF];
  logic [PHASE_W-1:0]    incr  [MOTORS_DEF];
  logic [LEVELS_W-1:0]   pulse_bits;
  logic [LEVELS_W-1:0]   dir_pins;
  logic [MAX_FREQ_W-1:0] max_freq_hz;
  logic [SCALE_W-1:0]    scale;
  pin_levels_t           levels_q[$];
  pin_levels_t           want_lv;
  pin_levels_t           next_lv;
  int                    errs;

  // Q.8 Hz request -> per-tick phase increment under the current registers
  function automatic logic [PHASE_W-1:0] step_increment(input logic [FREQ_W-1:0] fq8);
    logic [FREQ_W-1:0]             ceiling;
    logic [FREQ_W-1:0]             f;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W-INC_SHIFT-1:0]   shifted;
    ceiling = {max_freq_hz, {FRAC_BITS{1'b0}}};
    if (fq8 < FREQ_ONE_HZ) return '0;
    f = (fq8 > ceiling) ? ceiling : fq8;
    prod = PROD_W'(f) * PROD_W'(scale);
    shifted = prod[PROD_W-1:INC_SHIFT];
    if (|shifted[PROD_W-INC_SHIFT-1:PHASE_W]) return '1;
    return shifted[PHASE_W-1:0];
  endfunction

  task automatic advance_pins(input logic [OP_W-1:0] op, input logic [IN_TDATA_W-1:0] beat,
                              output pin_levels_t lv);
    logic [MOTOR_IDX_W-1:0] motor;
    logic [PHASE_W:0]       sum;
    motor = beat[MOTOR_IDX_W-1:0];
    case (op)
      OP_TICK: begin
        for (int i = 0; i < MOTORS_DEF; i++) begin
          pulse_bits[i] = 1'b0;
          if (incr[i] != '0) begin
            sum = {1'b0, accum[i]} + {1'b0, incr[i]};
            accum[i] = sum[PHASE_W-1:0];
            pulse_bits[i] = sum[PHASE_W];
          end
        end
      end
      OP_SET_FREQ: begin
        if (motor < MOTORS_DEF) incr[motor] = step_increment(beat[MOTOR_IDX_W +: FREQ_W]);
      end
      OP_SET_DIR: begin
        if (motor < MOTORS_DEF) dir_pins[motor] = beat[MOTOR_IDX_W + FREQ_W];
      end
      default: ;
    endcase
    lv.steps = pulse_bits;
    lv.dirs  = dir_pins;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MOTORS_DEF; i++) begin
        accum[i] = '0;
        incr[i]  = '0;
      end
      pulse_bits  = '0;
      dir_pins    = '0;
      max_freq_hz = MAX_FREQ_RST;
      scale       = SCALE_RST;
      levels_q.delete();
      errs = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // output side first: a beat can never belong to the command taken on this edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (levels_q.size() == 0) begin
          $display("%0t mdsg: unexpected result beat, expected none, got %h",
                   $time, m_axis_tdata);
          errs++;
        end else begin
          want_lv = levels_q.pop_front();
          if (m_axis_tdata[LEVELS_W-1:0] !== want_lv.steps) begin
            $display("%0t mdsg: step_levels expected %02h got %02h",
                     $time, want_lv.steps, m_axis_tdata[LEVELS_W-1:0]);
            errs++;
          end
          if (m_axis_tdata[2*LEVELS_W-1:LEVELS_W] !== want_lv.dirs) begin
            $display("%0t mdsg: direction_levels expected %02h got %02h",
                     $time, want_lv.dirs, m_axis_tdata[2*LEVELS_W-1:LEVELS_W]);
            errs++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_MAX_FREQ:    max_freq_hz = cfg_wdata_i[MAX_FREQ_W-1:0];
          CFG_PHASE_SCALE: scale = cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_pins(s_axis_tuser, s_axis_tdata, next_lv);
        levels_q.push_back(next_lv);
      end
      errors_o  <= errs;
      pending_o <= levels_q.size();
    end
  end

endmodule

// File: sim/tb_multi_axis_dds_step_generator.sv
module tb_multi_axis_dds_step_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import mdsg_pkg::*;

  localparam int unsigned       WATCHDOG_CYCLES = 200000;
  localparam int unsigned       SETTLE_CYCLES   = 16;
  localparam int unsigned       LONG_HOLD       = 400;
  localparam logic [OP_W-1:0]   OP_UNUSED       = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_addr_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  int                     errors;
  int                     pending;
  logic [MAX_FREQ_W-1:0]  cur_max_hz = MAX_FREQ_RST;
  bit                     quiet_tail = 1'b0;
  bit                     pressure_go = 1'b0;

  multi_axis_dds_step_generator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  mdsg_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // result side: random stall bursts, one long hold-off, none in the tail
  initial begin : rx_side
    bit held_long;
    held_long = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure_go && !held_long) begin
        held_long = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [MOTOR_IDX_W-1:0] motor,
                          input logic [FREQ_W-1:0] fq8, input logic fwd);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_TDATA_W'({fwd, fq8, motor});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait until every result beat is back and the pipeline has gone quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [MAX_FREQ_W-1:0] max_hz,
                            input logic [SCALE_W-1:0] scl);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_MAX_FREQ;
    cfg_wdata_i <= CFG_DATA_W'(max_hz);
    @(posedge clk_i);
    cfg_addr_i  <= CFG_PHASE_SCALE;
    cfg_wdata_i <= CFG_DATA_W'(scl);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_max_hz = max_hz;
  endtask

  // biased toward the clamp edges and the sub-1 Hz cutoff
  function automatic logic [FREQ_W-1:0] pick_freq();
    logic [FREQ_W-1:0] ceiling;
    ceiling = {cur_max_hz, {FRAC_BITS{1'b0}}};
    case ($urandom_range(0, 9))
      0:       return FREQ_W'($urandom_range(0, 255));
      1:       return FREQ_ONE_HZ;
      2:       return ceiling;
      3:       return ceiling + 1'b1;
      4, 5:    return FREQ_W'($urandom());
      default: return ceiling - FREQ_W'($urandom_range(0, ceiling / 2));
    endcase
  endfunction

  task automatic run_random(input int unsigned n);
    int unsigned done;
    int unsigned pick;
    logic [MOTOR_IDX_W-1:0] motor;
    done = 0;
    while (done < n) begin
      pick  = $urandom_range(0, 19);
      motor = MOTOR_IDX_W'($urandom_range(0, MOTORS_DEF - 1));
      if (pick < 9) begin
        send_cmd(OP_TICK, MOTOR_IDX_W'($urandom()), FREQ_W'($urandom()), 1'($urandom()));
        done++;
      end else if (pick < 15) begin
        send_cmd(OP_SET_FREQ, motor, pick_freq(), 1'($urandom()));
        done++;
      end else if (pick < 18) begin
        send_cmd(OP_SET_DIR, motor, FREQ_W'($urandom()), 1'($urandom()));
        done++;
      end else if (pick == 18) begin
        send_cmd(OP_UNUSED, MOTOR_IDX_W'($urandom()), FREQ_W'($urandom()), 1'($urandom()));
        done++;
      end else begin
        send_cmd(OP_W'($urandom_range(OP_SET_FREQ, OP_SET_DIR)),
                 MOTOR_IDX_W'($urandom_range(MOTORS_DEF, 7)), pick_freq(), 1'($urandom()));
        done++;
      end
    end
  endtask

  initial begin : stimulus
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_TICK;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CFG_MAX_FREQ;
    cfg_wdata_i   <= '0;
    rst_ni        <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: direction latching, ignored commands, clamp and cutoff edges
    send_cmd(OP_TICK, '0, '0, 1'b0);
    send_cmd(OP_SET_DIR, 3'd0, '0, 1'b1);
    send_cmd(OP_SET_DIR, 3'd5, '0, 1'b1);
    send_cmd(OP_SET_DIR, 3'd6, '0, 1'b1);
    send_cmd(OP_SET_DIR, 3'd7, '1, 1'b0);
    send_cmd(OP_SET_FREQ, 3'd7, '1, 1'b1);
    send_cmd(OP_UNUSED, '1, '1, 1'b1);
    send_cmd(OP_SET_FREQ, 3'd0, '1, 1'b0);
    send_cmd(OP_SET_FREQ, 3'd1, FREQ_ONE_HZ - 1'b1, 1'b0);
    send_cmd(OP_SET_FREQ, 3'd2, FREQ_ONE_HZ, 1'b0);
    send_cmd(OP_SET_FREQ, 3'd3, {MAX_FREQ_RST, {FRAC_BITS{1'b0}}}, 1'b0);
    send_cmd(OP_SET_FREQ, 3'd4, {MAX_FREQ_RST, {FRAC_BITS{1'b0}}} + 1'b1, 1'b0);
    send_cmd(OP_SET_FREQ, 3'd5, '0, 1'b0);
    repeat (4) send_cmd(OP_TICK, '0, '0, 1'b0);
    send_cmd(OP_SET_DIR, 3'd0, '0, 1'b0);
    send_cmd(OP_SET_FREQ, 3'd0, '0, 1'b0);
    repeat (2) send_cmd(OP_TICK, '1, '1, 1'b1);

    pressure_go = 1'b1;
    run_random(150);

    // full-scale registers: increment saturates
    drain();
    write_regs('1, '1);
    send_cmd(OP_SET_FREQ, 3'd0, '1, 1'b0);
    send_cmd(OP_SET_FREQ, 3'd1, '1, 1'b0);
    send_cmd(OP_SET_FREQ, 3'd2, '1, 1'b0);
    repeat (2) send_cmd(OP_TICK, '0, '0, 1'b0);
    run_random(130);

    drain();
    write_regs(MAX_FREQ_W'(1), SCALE_W'(1));
    run_random(80);

    // zero registers: every request ends up with a zero increment
    drain();
    write_regs('0, '0);
    run_random(60);

    repeat (3) begin
      drain();
      write_regs(MAX_FREQ_W'($urandom_range(1, 32767)),
                 SCALE_W'($urandom_range(1 << 24, (1 << SCALE_W) - 1)));
      run_random(80);
    end

    drain();
    write_regs(MAX_FREQ_RST, SCALE_RST);
    quiet_tail = 1'b1;
    run_random(140);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
